[sv/deq_pkg.sv]
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes, field widths, default sizes and the control
// and status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default sizes of the ring store.
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed widths of the channel fields.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the incoming word into the command register
    logic execute;  // update pointers and count, access the store
    logic load;     // fill the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy; // output register holds a word that is not taken
  } ctrl_sts_t;

endpackage

[sv/deq_cmd_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Carries one queue command and the word to push.
// ----------------------------------------------------------------------------
interface deq_cmd_if
  import deq_pkg::*;
  ();

  logic                      valid;
  logic                      ready;
  logic        [CMD_W-1:0]   command;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);

endinterface

[sv/deq_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Carries the word read, the fill count and the status of one command.
// ----------------------------------------------------------------------------
interface deq_res_if
  import deq_pkg::*;
  ();

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  read_value;
  logic        [FILL_W-1:0]   fill_count;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, output read_value, output fill_count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input fill_count, input status,
                  output ready);

endinterface

[sv/deq_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data with a read
// enable.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed entry; the read data is registered and holds its
  // value in cycles without a read, and a read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[sv/deq_datapath.sv]
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Command register, ring pointers, element count, ring store and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_cmd_t                  ctrl,
  output ctrl_sts_t                  sts,
  input  logic        [CMD_W-1:0]    command,
  input  logic signed [VALUE_W-1:0]  push_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  read_value,
  output logic        [FILL_W-1:0]   fill_count,
  output logic        [STATUS_W-1:0] status
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int XW  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int XCW = (CW > FILL_W) ? CW : FILL_W;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
    slot_next = (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
    slot_prev = (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  logic [CMD_W-1:0]      cmd_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [AW-1:0]         front;
  logic [AW-1:0]         back;
  logic [CW-1:0]         count;
  logic                  rd_sel;
  logic [STATUS_W-1:0]   status_q;

  logic [XW-1:0]         push_ext;
  logic                  is_push;
  logic                  is_read;
  logic                  is_back;
  logic                  is_pop;
  logic                  full;
  logic                  empty;
  logic                  ram_we;
  logic                  ram_rd;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [XW-1:0]         rd_ext;
  logic [XCW-1:0]        count_ext;

  // Keep only the low bits of the pushed word, zero above the field.
  assign push_ext = XW'($unsigned(push_value));

  // Capture the accepted command.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q  <= command;
      word_q <= push_ext[DATA_WIDTH-1:0];
    end
  end

  // Decode the held command.
  assign is_push = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_PUSH_FRONT);
  assign is_read = (cmd_q == CMD_POP_BACK) || (cmd_q == CMD_POP_FRONT) ||
                   (cmd_q == CMD_PEEK_BACK) || (cmd_q == CMD_PEEK_FRONT);
  assign is_back = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_POP_BACK) ||
                   (cmd_q == CMD_PEEK_BACK);
  assign is_pop  = (cmd_q == CMD_POP_BACK) || (cmd_q == CMD_POP_FRONT);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign ram_we  = ctrl.execute && is_push && !full;
  assign ram_rd  = is_read && !empty;

  // Store address: the slot written by a push or the end slot read.
  always_comb begin
    if (is_back) begin
      ram_addr = is_push ? back : slot_prev(back);
    end else begin
      ram_addr = is_push ? slot_prev(front) : front;
    end
  end

  // The read data is taken only in the execute step, so it holds while
  // the load step waits for the receiver.
  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ctrl.execute),
    .addr  (ram_addr),
    .wdata (word_q),
    .rdata (ram_rdata)
  );

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else if (ctrl.execute) begin
      if (cmd_q == CMD_CLEAR) begin
        front <= '0;
        back  <= '0;
        count <= '0;
      end else if (is_push && !full) begin
        if (is_back) begin
          back <= slot_next(back);
        end else begin
          front <= slot_prev(front);
        end
        count <= count + 1'b1;
      end else if (is_pop && !empty) begin
        if (is_back) begin
          back <= slot_prev(back);
        end else begin
          front <= slot_next(front);
        end
        count <= count - 1'b1;
      end
    end
  end

  // Status and read selection of the executed command.
  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      rd_sel <= ram_rd;
      if (is_push && full) begin
        status_q <= STS_FULL;
      end else if (is_read && empty) begin
        status_q <= STS_EMPTY;
      end else begin
        status_q <= STS_OK;
      end
    end
  end

  assign rd_ext    = XW'($signed(ram_rdata));
  assign count_ext = XCW'(count);

  // Output register of the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      read_value <= rd_sel ? $signed(rd_ext[VALUE_W-1:0]) : '0;
      fill_count <= count_ext[FILL_W-1:0];
      status     <= status_q;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

  // The count never exceeds the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("element count above depth");

  // Pointers stay inside the store.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(front) < DEPTH) && (int'(back) < DEPTH))
    else $error("ring pointer outside the store");

  // The back pointer lies count slots past the front pointer.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (((int'(front) + int'(count)) >= DEPTH) ?
       (int'(front) + int'(count) - DEPTH) : (int'(front) + int'(count))) == int'(back))
    else $error("pointers disagree with the element count");

endmodule

[sv/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Steps each accepted command through execute and output load.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output ctrl_cmd_t ctrl,
  input  ctrl_sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    ctrl.load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.execute = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        if (!sts.out_busy) begin
          ctrl.load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A captured command is executed in the next cycle.
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture |=> ctrl.execute)
    else $error("captured command not executed");

  // Execution is followed by the load step.
  a_exec_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.execute |=> (state == ST_LOAD))
    else $error("execution not followed by load");

  // The output register is never overwritten while a word waits in it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |-> !sts.out_busy)
    else $error("output overwritten before it was taken");

endmodule

[sv/double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// Double-ended queue unit
// A bounded ring of signed words with push, pop and peek at both ends.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word (command, push_value); res returns one
//   word per command (read_value, fill_count, status). Both channels use a
//   valid/ready handshake; a word moves on a clock edge with both high.
//   A push into a full ring is dropped with status full; a pop or peek on
//   an empty ring returns zero with status empty. Clear empties the ring.
//   Each accepted command is captured, then executed (pointer update and
//   registered read of the single-port ring store), then loaded into the
//   output register; a new command is accepted only after that load.
//   The next command is taken while a finished result still waits in the
//   output register; if the receiver stalls, processing halts at the load
//   step until the waiting result is taken.
//   Reset (rst, synchronous) empties the ring and drops any pending
//   result; the store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  deq_cmd_if.sink    cmd,
  deq_res_if.source  res
);

  ctrl_cmd_t ctrl;
  ctrl_sts_t sts;

  // Sequencing of each command.
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .ctrl     (ctrl),
    .sts      (sts)
  );

  // Ring store, pointers and output register.
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sts        (sts),
    .command    (cmd.command),
    .push_value (cmd.push_value),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .read_value (res.read_value),
    .fill_count (res.fill_count),
    .status     (res.status)
  );

endmodule
